[rtl/core/ohbd_pkg.sv]
// ---------------------------------------------------------------------------
// ohbd_pkg: shared constants of the optical heart beat detector
// Widths, low-pass tap table and configuration register indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package ohbd_pkg;
    localparam int SampleW = 18;
    localparam int RingD   = 32;
    localparam int PosW    = 5;
    localparam int AcW     = 21;
    localparam int FiltW   = 29;
    localparam int AccW    = 40;
    localparam int SumW    = 23;
    localparam int TapW    = 14;

    localparam logic [1:0] CfgMinAmp  = 2'd0;
    localparam logic [1:0] CfgMaxAmp  = 2'd1;
    localparam logic [1:0] CfgRiseLim = 2'd2;

    function automatic logic signed [TapW-1:0] fir_tap(input logic [3:0] k);
        logic signed [TapW-1:0] t;
        begin
            case (k)
                4'd0:  t = -14'sd111;
                4'd1:  t = -14'sd83;
                4'd2:  t = -14'sd10;
                4'd3:  t = 14'sd202;
                4'd4:  t = 14'sd603;
                4'd5:  t = 14'sd1212;
                4'd6:  t = 14'sd2009;
                4'd7:  t = 14'sd2923;
                4'd8:  t = 14'sd3842;
                4'd9:  t = 14'sd4632;
                4'd10: t = 14'sd5167;
                4'd11: t = 14'sd5356;
                default: t = 14'sd0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/core/optical_heart_beat_detector_unit.sv]
// ---------------------------------------------------------------------------
// optical_heart_beat_detector_unit: optical heart beat detector
// DC removal by two moving means, 23-tap low-pass, three-point shape detect.
// ---------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_stall carries one 18-bit ir sample per beat.
//   output channel o_valid/i_stall carries beat flag, dc estimate and the
//   filtered value for every sample, one result per sample.
//   config channel i_cfg_valid/o_cfg_ready writes min/max amplitude and the
//   rise run limit by index; writes are taken at any time.
// timing:
//   a sample is taken only in idle; after the accept the block sums the raw
//   ring and the mean ring, forms the dc estimate, writes the ac value, runs
//   the two-stage tap pipeline feeding the shared multiplier, then does the
//   last accumulate and the output step; the next sample is taken once the
//   block is back in idle. the raw and mean rings are read one entry per
//   cycle, the ac ring at two addresses at once.
// reset:
//   synchronous active low; afterward a clearing pass zeroes the three rings
//   before the first sample is taken.
// stall:
//   the result waits in the output register; the block then takes the next
//   sample and holds in its output step until the waiting result is taken.
`default_nettype none
module optical_heart_beat_detector_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [ohbd_pkg::SampleW-1:0]     i_ir_sample,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_beat,
    output logic [ohbd_pkg::SampleW-1:0]          o_dc_estimate,
    output logic signed [ohbd_pkg::FiltW-1:0]     o_filtered,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [1:0]                       i_cfg_index,
    input  wire logic [31:0]                      i_cfg_data
);
    localparam int PW = ohbd_pkg::PosW;
    localparam int SW = ohbd_pkg::SampleW;
    localparam int FW = ohbd_pkg::FiltW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RAW, ST_MEAN, ST_AC, ST_FIR, ST_FIRACC, ST_SHAPE, ST_OUT
    } t_state;

    t_state r_state;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] r_dc_pos, r_fir_pos;
    logic [SW-1:0] r_sample;
    logic [ohbd_pkg::SumW-1:0] r_sum;
    logic [SW-1:0] r_mean, r_est, r_oldest;
    logic signed [ohbd_pkg::AccW-1:0] r_acc;
    logic signed [ohbd_pkg::AcW:0] r_pair;
    logic [3:0] r_tap;
    logic [27:0] r_min_amp;
    logic [28:0] r_max_amp;
    logic [3:0]  r_rise_lim, r_rise;
    logic signed [FW-1:0] r_p1, r_p2, r_valley, r_peak;
    logic r_mvalley, r_valley_f, r_mpeak;
    logic [SW-1:0] raw_mem  [ohbd_pkg::RingD];
    logic [SW-1:0] mean_mem [ohbd_pkg::RingD];
    logic signed [ohbd_pkg::AcW-1:0] ac_mem [ohbd_pkg::RingD];
    logic [SW-1:0] r_raw_rd, r_mean_rd;
    logic signed [ohbd_pkg::AcW-1:0] r_ac_a, r_ac_b;
    logic r_ovalid, r_obeat;
    logic [SW-1:0] r_odc;
    logic signed [FW-1:0] r_ofilt;

    logic [PW-1:0] rd_idx, ac_a_idx, ac_b_idx;
    logic [PW:0] cnt_m1;
    logic [3:0] tap_m2;
    logic signed [ohbd_pkg::AcW:0] pair_sum;
    logic signed [ohbd_pkg::AcW+ohbd_pkg::TapW:0] prod;
    logic signed [ohbd_pkg::AccW-1:0] shifted;
    logic signed [FW-1:0] cur;
    logic signed [SW+2:0] ac_val;
    logic eq21, lt21, gt21, lt1c, gt1c, eq1c;
    logic n_mvalley, n_valley_f, n_mpeak, n_peak_f, n_beat;
    logic signed [FW-1:0] n_valley, n_peak;
    logic [3:0] n_rise;
    logic signed [FW:0] amp;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_beat        = r_obeat;
    assign o_dc_estimate = r_odc;
    assign o_filtered    = r_ofilt;

    // ring read address during sweeps; slot 0..31 by count
    assign rd_idx = r_cnt[PW-1:0];
    assign cnt_m1 = r_cnt - 1'b1;
    // read data and pair register put the tap two steps behind the count
    assign tap_m2 = r_tap - 4'd2;
    assign ac_a_idx = r_fir_pos - PW'(r_tap);
    assign ac_b_idx = r_fir_pos - PW'(22) + PW'(r_tap);
    assign pair_sum = (r_tap == 4'd12) ? {r_ac_a[ohbd_pkg::AcW-1], r_ac_a}
                    : ({r_ac_a[ohbd_pkg::AcW-1], r_ac_a} + {r_ac_b[ohbd_pkg::AcW-1], r_ac_b});
    assign prod = r_pair * ohbd_pkg::fir_tap(tap_m2);
    assign ac_val = ($signed({3'b0, r_est}) - $signed({3'b0, r_oldest})) <<< 2;
    assign shifted = r_acc >>> 8;
    assign cur = FW'(-shifted);

    always_comb begin
        eq21 = (r_p2 == r_p1);
        lt21 = (r_p2 < r_p1);
        gt21 = (r_p2 > r_p1);
        lt1c = (r_p1 < cur);
        gt1c = (r_p1 > cur);
        eq1c = (r_p1 == cur);
        n_mvalley = r_mvalley; n_valley_f = r_valley_f; n_mpeak = r_mpeak;
        n_peak_f = 1'b0; n_valley = r_valley; n_peak = r_peak; n_rise = r_rise;
        n_beat = 1'b0;
        if (eq21 && lt1c) begin
            if (r_mvalley) begin
                n_valley_f = 1'b1; n_valley = r_p1; n_mvalley = 1'b0;
            end
            n_mpeak = 1'b0;
        end
        if (eq21 && gt1c) begin
            n_mvalley = 1'b0;
            if (r_mpeak && r_p1 > 0) begin
                n_mpeak = 1'b0; n_peak_f = 1'b1; n_peak = r_p1;
            end
        end
        if (lt21 && eq1c) n_mpeak = 1'b1;
        if (lt21 && gt1c && r_p1 > 0) begin
            n_peak_f = 1'b1; n_peak = r_p1;
        end
        if (gt21 && lt1c) begin
            n_valley_f = 1'b1; n_valley = r_p1;
        end
        if (gt21 && eq1c) n_mvalley = 1'b1;
        if (r_rise < r_rise_lim) begin
            n_rise = (!gt1c) ? r_rise + 4'd1 : 4'd0;
        end
        amp = {n_peak[FW-1], n_peak} - {n_valley[FW-1], n_valley};
        if (n_peak_f) begin
            n_beat = n_valley_f && (n_rise == r_rise_lim)
                   && (amp > $signed({2'b0, r_min_amp}))
                   && (amp < $signed({1'b0, r_max_amp}));
            n_mpeak = 1'b0; n_mvalley = 1'b0; n_valley_f = 1'b0; n_rise = 4'd0;
        end
    end

    // ring memories: one write, registered reads
    always_ff @(posedge i_clk) begin
        r_raw_rd  <= raw_mem[rd_idx];
        r_mean_rd <= mean_mem[rd_idx];
        r_ac_a    <= ac_mem[ac_a_idx];
        r_ac_b    <= ac_mem[ac_b_idx];
        if (r_state == ST_CLEAR) begin
            raw_mem[rd_idx]  <= '0;
            mean_mem[rd_idx] <= '0;
            ac_mem[rd_idx]   <= '0;
        end else if (r_state == ST_IDLE && i_valid && !o_stall) begin
            raw_mem[r_dc_pos] <= i_ir_sample;
        end else if (r_state == ST_MEAN && r_cnt == '0) begin
            mean_mem[r_dc_pos] <= r_sum[ohbd_pkg::SumW-1:PW];
        end else if (r_state == ST_FIR) begin
            ac_mem[r_fir_pos] <= ohbd_pkg::AcW'(ac_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_cnt <= '0; r_dc_pos <= '0; r_fir_pos <= '0;
            r_p1 <= '0; r_p2 <= '0; r_valley <= '0; r_peak <= '0;
            r_mvalley <= 1'b0; r_valley_f <= 1'b0; r_mpeak <= 1'b0; r_rise <= '0;
            r_min_amp <= 28'd75; r_max_amp <= 29'd2500000; r_rise_lim <= 4'd6;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ohbd_pkg::CfgMinAmp:  r_min_amp  <= i_cfg_data[27:0];
                    ohbd_pkg::CfgMaxAmp:  r_max_amp  <= i_cfg_data[28:0];
                    ohbd_pkg::CfgRiseLim: r_rise_lim <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(ohbd_pkg::RingD - 1)) begin
                        r_cnt <= '0; r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_sample <= i_ir_sample;
                        r_cnt <= '0; r_sum <= '0; r_state <= ST_RAW;
                    end
                end
                ST_RAW: begin
                    // read data arrives the cycle after its address; written slot uses the new sample
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0)
                        r_sum <= r_sum + ((cnt_m1[PW-1:0] == r_dc_pos) ?
                                 ohbd_pkg::SumW'(r_sample) : ohbd_pkg::SumW'(r_raw_rd));
                    if (r_cnt == 6'(ohbd_pkg::RingD)) begin
                        r_cnt <= '0; r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (r_cnt == '0) begin
                        r_mean <= r_sum[ohbd_pkg::SumW-1:PW];
                        r_sum <= '0;
                    end else begin
                        r_sum <= r_sum + ((cnt_m1[PW-1:0] == r_dc_pos) ?
                                 ohbd_pkg::SumW'(r_mean) : ohbd_pkg::SumW'(r_mean_rd));
                    end
                    // raw read data holds the slot one behind the count
                    if (r_cnt != '0 && cnt_m1[PW-1:0] == PW'(r_dc_pos + 1'b1))
                        r_oldest <= r_raw_rd;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(ohbd_pkg::RingD)) begin
                        r_cnt <= '0; r_state <= ST_AC;
                    end
                end
                ST_AC: begin
                    r_est <= r_sum[ohbd_pkg::SumW-1:PW];
                    r_state <= ST_FIR;
                end
                ST_FIR: begin
                    // ac write lands this cycle, reads start next
                    r_acc <= '0; r_tap <= '0; r_state <= ST_FIRACC;
                end
                ST_FIRACC: begin
                    if (r_tap != '0) r_pair <= pair_sum;
                    if (r_tap > 4'd1) r_acc <= r_acc + ohbd_pkg::AccW'(prod);
                    r_tap <= r_tap + 4'd1;
                    if (r_tap == 4'd13) r_state <= ST_SHAPE;
                end
                ST_SHAPE: begin
                    r_acc <= r_acc + ohbd_pkg::AccW'(prod);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1; r_obeat <= n_beat;
                        r_odc <= r_est; r_ofilt <= cur;
                        r_p2 <= r_p1; r_p1 <= cur;
                        r_mvalley <= n_mvalley; r_valley_f <= n_valley_f;
                        r_mpeak <= n_mpeak; r_valley <= n_valley;
                        r_peak <= n_peak; r_rise <= n_rise;
                        r_dc_pos <= r_dc_pos + 1'b1; r_fir_pos <= r_fir_pos + 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[verif/tb_optical_heart_beat_detector_unit.sv]
// ---------------------------------------------------------------------------
// tb_optical_heart_beat_detector_unit: self-checking bench of the detector
// Drives ir samples with bursty timing, stalls the result side on a pattern
// of its own, and checks every result against a cycle-free software model.
// ---------------------------------------------------------------------------
`default_nettype none

class hb_scoreboard;
    typedef struct {
        logic                                 beat;
        logic [ohbd_pkg::SampleW-1:0]         dc;
        logic signed [ohbd_pkg::FiltW-1:0]    filt;
    } hb_result_t;

    hb_result_t  due_q[$];
    int          err_cnt;

    // detector model state
    longint      lp_coef[12];
    int unsigned raw_mem[32];
    int unsigned mean_mem[32];
    int unsigned dc_idx;
    longint      ac_mem[32];
    int unsigned lp_idx;
    longint      last_f, last2_f;
    bit          mvalley, valley_seen, mpeak, peak_seen;
    longint      valley_lvl, peak_lvl;
    int unsigned rise_cnt;
    longint      amp_lo, amp_hi;
    int unsigned rise_lim;

    function new();
        lp_coef = '{-111, -83, -10, 202, 603, 1212, 2009, 2923, 3842, 4632, 5167, 5356};
        foreach (raw_mem[k]) begin
            raw_mem[k] = 0;
            mean_mem[k] = 0;
            ac_mem[k] = 0;
        end
        dc_idx = 0;
        lp_idx = 0;
        last_f = 0;
        last2_f = 0;
        mvalley = 0;
        valley_seen = 0;
        mpeak = 0;
        peak_seen = 0;
        valley_lvl = 0;
        peak_lvl = 0;
        rise_cnt = 0;
        amp_lo = 75;
        amp_hi = 2500000;
        rise_lim = 6;
        err_cnt = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            ohbd_pkg::CfgMinAmp:  amp_lo = val[27:0];
            ohbd_pkg::CfgMaxAmp:  amp_hi = val[28:0];
            ohbd_pkg::CfgRiseLim: rise_lim = val[3:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    function void note_sample(logic [ohbd_pkg::SampleW-1:0] s);
        longint unsigned acc;
        longint est, z, cur, p1, p2, amp;
        int unsigned pos;
        hb_result_t r;
        bit beat;
        beat = 0;
        pos = dc_idx;
        p2 = last2_f;
        p1 = last_f;
        raw_mem[pos] = s;
        acc = 0;
        foreach (raw_mem[k]) acc += raw_mem[k];
        mean_mem[pos] = acc / 32;
        acc = 0;
        foreach (mean_mem[k]) acc += mean_mem[k];
        est = acc / 32;
        dc_idx = (pos + 1) % 32;
        ac_mem[lp_idx] = (est - longint'(raw_mem[dc_idx])) * 4;
        z = lp_coef[11] * ac_mem[(lp_idx - 11) & 31];
        for (int k = 0; k < 11; k++)
            z += lp_coef[k] * (ac_mem[(lp_idx - k) & 31] + ac_mem[(lp_idx - 22 + k) & 31]);
        lp_idx = (lp_idx + 1) & 31;
        cur = -(z >>> 8);
        last2_f = p1;
        last_f = cur;

        // three-point shape detection
        if (p2 == p1 && p1 < cur) begin
            if (mvalley) begin
                valley_seen = 1;
                valley_lvl = p1;
                mvalley = 0;
            end
            mpeak = 0;
        end
        if (p2 == p1 && p1 > cur) begin
            mvalley = 0;
            if (mpeak && p1 > 0) begin
                mpeak = 0;
                peak_seen = 1;
                peak_lvl = p1;
            end
        end
        if (p2 < p1 && p1 == cur) mpeak = 1;
        if (p2 < p1 && p1 > cur && p1 > 0) begin
            peak_seen = 1;
            peak_lvl = p1;
        end
        if (p2 > p1 && p1 < cur) begin
            valley_seen = 1;
            valley_lvl = p1;
        end
        if (p2 > p1 && p1 == cur) mvalley = 1;

        if (rise_cnt < rise_lim) begin
            if (p1 <= cur) rise_cnt++;
            else rise_cnt = 0;
        end
        if (peak_seen) begin
            amp = peak_lvl - valley_lvl;
            if (valley_seen && rise_cnt == rise_lim && amp > amp_lo && amp < amp_hi)
                beat = 1;
            mpeak = 0;
            mvalley = 0;
            peak_seen = 0;
            valley_seen = 0;
            rise_cnt = 0;
        end
        r.beat = beat;
        r.dc = est[ohbd_pkg::SampleW-1:0];
        r.filt = cur[ohbd_pkg::FiltW-1:0];
        due_q.push_back(r);
    endfunction

    function void check_result(logic b, logic [ohbd_pkg::SampleW-1:0] dc,
                               logic signed [ohbd_pkg::FiltW-1:0] f);
        hb_result_t r;
        if (due_q.size() == 0) begin
            $error("result with nothing expected: beat=%0d dc=%0d filtered=%0d", b, dc, f);
            err_cnt++;
            return;
        end
        r = due_q.pop_front();
        if (b !== r.beat) begin
            $error("beat: expected %0d, got %0d", r.beat, b);
            err_cnt++;
        end
        if (dc !== r.dc) begin
            $error("dc_estimate: expected %0d, got %0d", r.dc, dc);
            err_cnt++;
        end
        if (f !== r.filt) begin
            $error("filtered: expected %0d, got %0d", r.filt, f);
            err_cnt++;
        end
    endfunction
endclass

module tb_optical_heart_beat_detector_unit;
    localparam logic [1:0] CfgSpare = 2'd3;
    localparam int CycleLimit = 2000000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [ohbd_pkg::SampleW-1:0]         i_ir_sample;
    logic                                 o_valid;
    logic                                 i_stall;
    logic                                 o_beat;
    logic [ohbd_pkg::SampleW-1:0]         o_dc_estimate;
    logic signed [ohbd_pkg::FiltW-1:0]    o_filtered;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [1:0]                           i_cfg_index;
    logic [31:0]                          i_cfg_data;

    hb_scoreboard sb;
    int           cycles;
    int           burst_left;
    int           stall_mode;
    int           stall_hold;

    optical_heart_beat_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ir_sample   (i_ir_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_beat        (o_beat),
        .o_dc_estimate (o_dc_estimate),
        .o_filtered    (o_filtered),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        sb = new();
        cycles = 0;
        stall_mode = 0;
        stall_hold = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: free-flowing, light, half and heavy stretches
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(20, 400);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            1: i_stall <= ($urandom_range(0, 9) < 3);
            2: i_stall <= ($urandom_range(0, 99) < 90);
            3: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_sample(i_ir_sample);
            if (o_valid && !i_stall) sb.check_result(o_beat, o_dc_estimate, o_filtered);
        end
    end

    task automatic send_sample(logic [ohbd_pkg::SampleW-1:0] s);
        i_valid <= 1'b1;
        i_ir_sample <= s;
        do @(posedge i_clk); while (o_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            burst_left = $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // pulse-like waveform with random level, swing, period, flat tops and stray random samples
    task automatic pulse_train(int n);
        int base, swing, period, ph, v, flat;
        base = $urandom_range(500, 250000);
        swing = ($urandom_range(0, 7) == 0) ? $urandom_range(3000, 60000)
                                            : $urandom_range(2, 3000);
        period = $urandom_range(6, 48);
        ph = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                v = $urandom_range(0, 262143);
            end else begin
                v = (ph < period / 2) ? ph : period - ph;
                v = base + (swing * v) / (period / 2 + 1) + $urandom_range(0, 2);
                if (v > 262143) v = 262143;
            end
            flat = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 1;
            for (int j = 0; j < flat && k < n; j++, k++)
                send_sample(v[ohbd_pkg::SampleW-1:0]);
            k--;
            ph = (ph + 1) % period;
            if ($urandom_range(0, 99) == 0) drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ir_sample <= '0;
        i_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ohbd_pkg::CfgMinAmp;
        i_cfg_data <= '0;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, bit walk, alternating bits, flat runs
        send_sample('0);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        for (int k = 0; k < 18; k += 3) send_sample(18'd1 << k);
        send_sample(18'h2AAAA);
        send_sample(18'h15555);
        for (int k = 0; k < 4; k++) send_sample(18'd100000);
        for (int k = 0; k < 4; k++) send_sample(18'd140000);
        send_sample(18'd90000);
        drain();

        pulse_train(220);
        drain();
        write_reg(ohbd_pkg::CfgMinAmp, 32'd0);
        write_reg(ohbd_pkg::CfgMaxAmp, 32'h1FFF_FFFF);
        write_reg(ohbd_pkg::CfgRiseLim, 32'd1);
        pulse_train(220);
        drain();
        // wide data, masked to register width
        write_reg(ohbd_pkg::CfgMinAmp, 32'hFFFF_FFFF);
        write_reg(ohbd_pkg::CfgMaxAmp, 32'd0);
        write_reg(ohbd_pkg::CfgRiseLim, 32'd15);
        write_reg(CfgSpare, 32'h1234_5678);
        pulse_train(180);
        drain();
        // run zero: beat only when the run never counts
        write_reg(ohbd_pkg::CfgMinAmp, 32'd75);
        write_reg(ohbd_pkg::CfgMaxAmp, 32'd2500000);
        write_reg(ohbd_pkg::CfgRiseLim, 32'd0);
        pulse_train(200);
        drain();
        write_reg(ohbd_pkg::CfgMinAmp, 32'd20);
        write_reg(ohbd_pkg::CfgMaxAmp, 32'd200000);
        write_reg(ohbd_pkg::CfgRiseLim, 32'd12);
        pulse_train(200);
        drain();
        // lowered limit leaves the run above it
        write_reg(ohbd_pkg::CfgRiseLim, 32'd2);
        pulse_train(200);
        drain();
        write_reg(ohbd_pkg::CfgMinAmp, 32'h0FFF_FFFF);
        write_reg(ohbd_pkg::CfgMaxAmp, 32'h1FFF_FFFF);
        write_reg(ohbd_pkg::CfgRiseLim, 32'd6);
        pulse_train(100);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(ohbd_pkg::CfgMinAmp, $urandom_range(0, 2000));
            write_reg(ohbd_pkg::CfgMaxAmp, $urandom_range(1000, 5000000));
            write_reg(ohbd_pkg::CfgRiseLim, $urandom_range(1, 15));
            pulse_train(110);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire

[optical_heart_beat_detector_unit.f]
rtl/core/ohbd_pkg.sv
rtl/core/optical_heart_beat_detector_unit.sv
verif/tb_optical_heart_beat_detector_unit.sv
